/* sv/acpu_pkg.sv */
// Package: shared types, codes and constants of the accumulator CPU.
`timescale 1ns / 1ps
package acpu_pkg;

  localparam int WORD_BITS_DEF  = 32;
  localparam int MEM_WORDS      = 2000;
  localparam int ADDR_BITS      = 11;
  localparam int USER_LIMIT     = 1000;
  localparam int REG_LIMIT      = 2048;
  localparam int TIMER_VECTOR   = 1000;
  localparam int SYSCALL_VECTOR = 1500;
  localparam int SAVE_PC_ADDR   = MEM_WORDS - 1;
  localparam int SAVE_SP_ADDR   = MEM_WORDS - 2;
  localparam int OP_BITS        = 6;
  localparam logic [15:0] TIMER_RESET = 16'd30;

  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_STEP = 1'b1;

  localparam int PUT_INT  = 1;
  localparam int PUT_CHAR = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD_VALUE = 6'd1,  OP_LOAD_ADDR = 6'd2,  OP_LOAD_IND = 6'd3,
    OP_LOAD_IDX_X = 6'd4,  OP_LOAD_IDX_Y = 6'd5, OP_LOAD_SP_X = 6'd6,
    OP_STORE = 6'd7,       OP_GET = 6'd8,        OP_PUT = 6'd9,
    OP_ADD_X = 6'd10,      OP_ADD_Y = 6'd11,     OP_SUB_X = 6'd12,
    OP_SUB_Y = 6'd13,      OP_TO_X = 6'd14,      OP_FROM_X = 6'd15,
    OP_TO_Y = 6'd16,       OP_FROM_Y = 6'd17,    OP_TO_SP = 6'd18,
    OP_FROM_SP = 6'd19,    OP_JUMP = 6'd20,      OP_JEQ = 6'd21,
    OP_JNE = 6'd22,        OP_CALL = 6'd23,      OP_RET = 6'd24,
    OP_INC_X = 6'd25,      OP_DEC_X = 6'd26,     OP_PUSH = 6'd27,
    OP_POP = 6'd28,        OP_INT = 6'd29,       OP_IRET = 6'd30,
    OP_END = 6'd50
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_MEM     = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    INT_NONE    = 2'd0,
    INT_SYSCALL = 2'd1,
    INT_TIMER   = 2'd2
  } int_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TINT2, S_SINT2, S_FETCH, S_DECODE, S_OPER,
    S_IND, S_LOADAC, S_RETPC, S_IRET1, S_IRET2, S_DONE
  } state_t;

  typedef struct packed {
    logic                opcode;
    logic [10:0]         load_address;
    logic signed [31:0]  load_value;
    logic [6:0]          random_value;
  } req_t;

  typedef struct packed {
    logic                port_valid;
    logic                port_is_char;
    logic signed [31:0]  port_value;
    logic                halted;
    logic [1:0]          error_code;
  } rsp_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
  } mem_ctl_t;

  typedef struct packed {
    logic take;
    logic emit;
  } hs_t;

endpackage

/* sv/acpu_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/acpu_core.sv */
// CPU sequencer: registers, timer and instruction steps over the memory port.
`timescale 1ns / 1ps
module acpu_core #(
  parameter int WORD_BITS = acpu_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [15:0]          cfg_wdata,
  input  logic                 buf_valid,
  input  acpu_pkg::req_t       buf_req,
  input  logic                 out_free,
  output acpu_pkg::hs_t        hs,
  output acpu_pkg::rsp_t       rsp,
  output acpu_pkg::mem_ctl_t   mem_ctl,
  output logic [WORD_BITS-1:0] mem_wdata,
  input  logic [WORD_BITS-1:0] mem_rdata
);

  typedef logic [WORD_BITS-1:0] word_t;
  localparam int AB = acpu_pkg::ADDR_BITS;

  acpu_pkg::state_t    state, state_next;
  acpu_pkg::op_t       op, op_next;
  acpu_pkg::int_kind_t kind, kind_next;
  acpu_pkg::err_t      err, err_next;
  logic [AB-1:0] pc, pc_next, sp, sp_next;
  word_t ac, ac_next, x, x_next, y, y_next, s_tmp, s_tmp_next;
  logic kernel, kernel_next, pending, pending_next, stopped, stopped_next;
  logic stop, stop_next, put_v, put_v_next, put_char, put_char_next;
  logic [15:0] iut, iut_next, interval, interval_next;
  logic [6:0] rnd, rnd_next;
  word_t lim, sp_dec, rd_w, ea;
  logic [AB-1:0] sp_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= acpu_pkg::S_IDLE;
      kind     <= acpu_pkg::INT_NONE;
      err      <= acpu_pkg::ERR_NONE;
      pc       <= '0;
      sp       <= AB'(acpu_pkg::USER_LIMIT);
      ac       <= '0;
      x        <= '0;
      y        <= '0;
      kernel   <= 1'b0;
      pending  <= 1'b0;
      stopped  <= 1'b0;
      stop     <= 1'b0;
      put_v    <= 1'b0;
      put_char <= 1'b0;
      iut      <= acpu_pkg::TIMER_RESET;
      interval <= acpu_pkg::TIMER_RESET;
    end else begin
      state    <= state_next;
      kind     <= kind_next;
      err      <= err_next;
      pc       <= pc_next;
      sp       <= sp_next;
      ac       <= ac_next;
      x        <= x_next;
      y        <= y_next;
      kernel   <= kernel_next;
      pending  <= pending_next;
      stopped  <= stopped_next;
      stop     <= stop_next;
      put_v    <= put_v_next;
      put_char <= put_char_next;
      iut      <= iut_next;
      interval <= interval_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    s_tmp <= s_tmp_next;
    rnd   <= rnd_next;
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    kind_next     = kind;
    err_next      = err;
    pc_next       = pc;
    sp_next       = sp;
    ac_next       = ac;
    x_next        = x;
    y_next        = y;
    s_tmp_next    = s_tmp;
    kernel_next   = kernel;
    pending_next  = pending;
    stopped_next  = stopped;
    stop_next     = stop;
    put_v_next    = put_v;
    put_char_next = put_char;
    iut_next      = iut;
    interval_next = interval;
    rnd_next      = rnd;
    hs            = '0;
    rsp           = '0;
    mem_ctl       = '0;
    mem_wdata     = '0;
    lim    = kernel ? word_t'(acpu_pkg::MEM_WORDS) : word_t'(acpu_pkg::USER_LIMIT);
    sp_m1  = sp - AB'(1);
    sp_dec = word_t'(sp) - word_t'(1);
    rd_w   = mem_rdata;
    ea     = '0;

    case (state)
      acpu_pkg::S_IDLE: begin
        if (buf_valid) begin
          if (buf_req.opcode == acpu_pkg::ITEM_LOAD || stopped) begin
            if (out_free) begin
              hs.take = 1'b1;
              hs.emit = 1'b1;
              rsp.halted = stopped;
              if (buf_req.opcode == acpu_pkg::ITEM_LOAD &&
                  buf_req.load_address < AB'(acpu_pkg::MEM_WORDS)) begin
                mem_ctl.we   = 1'b1;
                mem_ctl.addr = buf_req.load_address;
                mem_wdata    = word_t'(buf_req.load_value);
              end
            end
          end else begin
            hs.take       = 1'b1;
            rnd_next      = buf_req.random_value;
            err_next      = acpu_pkg::ERR_NONE;
            stop_next     = 1'b0;
            put_v_next    = 1'b0;
            put_char_next = 1'b0;
            if (pending && kind == acpu_pkg::INT_NONE) begin
              pending_next = 1'b0;
              kernel_next  = 1'b1;
              kind_next    = acpu_pkg::INT_TIMER;
              mem_ctl.we   = 1'b1;
              mem_ctl.addr = AB'(acpu_pkg::SAVE_PC_ADDR);
              mem_wdata    = word_t'(pc);
              state_next   = acpu_pkg::S_TINT2;
            end else begin
              state_next = acpu_pkg::S_FETCH;
            end
          end
        end
      end
      acpu_pkg::S_TINT2, acpu_pkg::S_SINT2: begin
        mem_ctl.we   = 1'b1;
        mem_ctl.addr = AB'(acpu_pkg::SAVE_SP_ADDR);
        mem_wdata    = word_t'(sp);
        sp_next      = AB'(acpu_pkg::SAVE_SP_ADDR);
        if (state == acpu_pkg::S_TINT2) begin
          pc_next    = AB'(acpu_pkg::TIMER_VECTOR);
          state_next = acpu_pkg::S_FETCH;
        end else begin
          pc_next    = AB'(acpu_pkg::SYSCALL_VECTOR);
          state_next = acpu_pkg::S_DONE;
        end
      end
      acpu_pkg::S_FETCH: begin
        if (word_t'(pc) >= lim) begin
          stop_next = 1'b1;
          err_next  = acpu_pkg::ERR_MEM;
          state_next = acpu_pkg::S_DONE;
        end else begin
          mem_ctl.addr = pc;
          pc_next      = pc + AB'(1);
          state_next   = acpu_pkg::S_DECODE;
        end
      end
      acpu_pkg::S_DECODE: begin
        op_next    = acpu_pkg::op_t'(rd_w[acpu_pkg::OP_BITS-1:0]);
        state_next = acpu_pkg::S_DONE;
        if ((rd_w >> acpu_pkg::OP_BITS) != '0) begin
          err_next = acpu_pkg::ERR_INVALID;
        end else begin
          case (acpu_pkg::op_t'(rd_w[acpu_pkg::OP_BITS-1:0]))
            acpu_pkg::OP_LOAD_VALUE, acpu_pkg::OP_LOAD_ADDR, acpu_pkg::OP_LOAD_IND,
            acpu_pkg::OP_LOAD_IDX_X, acpu_pkg::OP_LOAD_IDX_Y, acpu_pkg::OP_STORE,
            acpu_pkg::OP_PUT, acpu_pkg::OP_JUMP, acpu_pkg::OP_JEQ, acpu_pkg::OP_JNE,
            acpu_pkg::OP_CALL: begin
              if (word_t'(pc) >= lim) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                mem_ctl.addr = pc;
                pc_next      = pc + AB'(1);
                state_next   = acpu_pkg::S_OPER;
              end
            end
            acpu_pkg::OP_LOAD_SP_X: begin
              ea = word_t'(sp) + x;
              if (ea >= lim) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                mem_ctl.addr = ea[AB-1:0];
                state_next   = acpu_pkg::S_LOADAC;
              end
            end
            acpu_pkg::OP_GET:     ac_next = word_t'(rnd);
            acpu_pkg::OP_ADD_X:   ac_next = ac + x;
            acpu_pkg::OP_ADD_Y:   ac_next = ac + y;
            acpu_pkg::OP_SUB_X:   ac_next = ac - x;
            acpu_pkg::OP_SUB_Y:   ac_next = ac - y;
            acpu_pkg::OP_TO_X:    x_next = ac;
            acpu_pkg::OP_FROM_X:  ac_next = x;
            acpu_pkg::OP_TO_Y:    y_next = ac;
            acpu_pkg::OP_FROM_Y:  ac_next = y;
            acpu_pkg::OP_TO_SP: begin
              if (ac >= word_t'(acpu_pkg::REG_LIMIT)) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                sp_next = ac[AB-1:0];
              end
            end
            acpu_pkg::OP_FROM_SP: ac_next = word_t'(sp);
            acpu_pkg::OP_INC_X:   x_next = x + word_t'(1);
            acpu_pkg::OP_DEC_X:   x_next = x - word_t'(1);
            acpu_pkg::OP_RET, acpu_pkg::OP_POP, acpu_pkg::OP_IRET: begin
              if (word_t'(sp) >= lim) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                mem_ctl.addr = sp;
                sp_next      = sp + AB'(1);
                if (rd_w[acpu_pkg::OP_BITS-1:0] == acpu_pkg::OP_RET) begin
                  state_next = acpu_pkg::S_RETPC;
                end else if (rd_w[acpu_pkg::OP_BITS-1:0] == acpu_pkg::OP_POP) begin
                  state_next = acpu_pkg::S_LOADAC;
                end else begin
                  state_next = acpu_pkg::S_IRET1;
                end
              end
            end
            acpu_pkg::OP_PUSH: begin
              if (sp == '0 || sp_dec >= lim) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                mem_ctl.we   = 1'b1;
                mem_ctl.addr = sp_m1;
                mem_wdata    = ac;
                sp_next      = sp_m1;
              end
            end
            acpu_pkg::OP_INT: begin
              if (kind == acpu_pkg::INT_NONE) begin
                kernel_next  = 1'b1;
                kind_next    = acpu_pkg::INT_SYSCALL;
                mem_ctl.we   = 1'b1;
                mem_ctl.addr = AB'(acpu_pkg::SAVE_PC_ADDR);
                mem_wdata    = word_t'(pc);
                state_next   = acpu_pkg::S_SINT2;
              end
            end
            acpu_pkg::OP_END: begin
              stop_next = 1'b1;
              err_next  = acpu_pkg::ERR_NONE;
            end
            default: err_next = acpu_pkg::ERR_INVALID;
          endcase
        end
      end
      acpu_pkg::S_OPER: begin
        state_next = acpu_pkg::S_DONE;
        case (op)
          acpu_pkg::OP_LOAD_VALUE: ac_next = rd_w;
          acpu_pkg::OP_LOAD_ADDR, acpu_pkg::OP_LOAD_IND, acpu_pkg::OP_LOAD_IDX_X,
          acpu_pkg::OP_LOAD_IDX_Y, acpu_pkg::OP_STORE: begin
            if (op == acpu_pkg::OP_LOAD_IDX_X) begin
              ea = rd_w + x;
            end else if (op == acpu_pkg::OP_LOAD_IDX_Y) begin
              ea = rd_w + y;
            end else begin
              ea = rd_w;
            end
            if (ea >= lim) begin
              stop_next = 1'b1;
              err_next  = acpu_pkg::ERR_MEM;
            end else begin
              mem_ctl.addr = ea[AB-1:0];
              if (op == acpu_pkg::OP_STORE) begin
                mem_ctl.we = 1'b1;
                mem_wdata  = ac;
              end else if (op == acpu_pkg::OP_LOAD_IND) begin
                state_next = acpu_pkg::S_IND;
              end else begin
                state_next = acpu_pkg::S_LOADAC;
              end
            end
          end
          acpu_pkg::OP_PUT: begin
            if (rd_w == word_t'(acpu_pkg::PUT_INT) || rd_w == word_t'(acpu_pkg::PUT_CHAR)) begin
              put_v_next    = 1'b1;
              put_char_next = (rd_w == word_t'(acpu_pkg::PUT_CHAR));
            end
          end
          acpu_pkg::OP_JUMP, acpu_pkg::OP_JEQ, acpu_pkg::OP_JNE, acpu_pkg::OP_CALL: begin
            if (op == acpu_pkg::OP_CALL) begin
              if (sp == '0 || sp_dec >= lim) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                mem_ctl.we   = 1'b1;
                mem_ctl.addr = sp_m1;
                mem_wdata    = word_t'(pc);
                sp_next      = sp_m1;
              end
            end
            if (op == acpu_pkg::OP_JUMP || op == acpu_pkg::OP_CALL ||
                (op == acpu_pkg::OP_JEQ && ac == '0) ||
                (op == acpu_pkg::OP_JNE && ac != '0)) begin
              if (rd_w >= word_t'(acpu_pkg::REG_LIMIT)) begin
                stop_next = 1'b1;
                err_next  = acpu_pkg::ERR_MEM;
              end else begin
                pc_next = rd_w[AB-1:0];
              end
            end
          end
          default: ;
        endcase
      end
      acpu_pkg::S_IND: begin
        if (rd_w >= lim) begin
          stop_next  = 1'b1;
          err_next   = acpu_pkg::ERR_MEM;
          state_next = acpu_pkg::S_DONE;
        end else begin
          mem_ctl.addr = rd_w[AB-1:0];
          state_next   = acpu_pkg::S_LOADAC;
        end
      end
      acpu_pkg::S_LOADAC: begin
        ac_next    = rd_w;
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_RETPC: begin
        if (rd_w >= word_t'(acpu_pkg::REG_LIMIT)) begin
          stop_next = 1'b1;
          err_next  = acpu_pkg::ERR_MEM;
        end else begin
          pc_next = rd_w[AB-1:0];
        end
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_IRET1: begin
        s_tmp_next = rd_w;
        if (word_t'(sp) >= lim) begin
          stop_next  = 1'b1;
          err_next   = acpu_pkg::ERR_MEM;
          state_next = acpu_pkg::S_DONE;
        end else begin
          mem_ctl.addr = sp;
          sp_next      = sp + AB'(1);
          state_next   = acpu_pkg::S_IRET2;
        end
      end
      acpu_pkg::S_IRET2: begin
        if (kind == acpu_pkg::INT_TIMER) begin
          pending_next = 1'b0;
        end
        kind_next   = acpu_pkg::INT_NONE;
        kernel_next = 1'b0;
        if (s_tmp >= word_t'(acpu_pkg::REG_LIMIT) || rd_w >= word_t'(acpu_pkg::REG_LIMIT)) begin
          stop_next = 1'b1;
          err_next  = acpu_pkg::ERR_MEM;
        end else begin
          sp_next = s_tmp[AB-1:0];
          pc_next = rd_w[AB-1:0];
        end
        state_next = acpu_pkg::S_DONE;
      end
      acpu_pkg::S_DONE: begin
        if (out_free) begin
          hs.emit    = 1'b1;
          state_next = acpu_pkg::S_IDLE;
          rsp.error_code = err;
          if (stop) begin
            stopped_next = 1'b1;
            rsp.halted   = 1'b1;
          end else begin
            rsp.port_valid   = put_v;
            rsp.port_is_char = put_v & put_char;
            rsp.port_value   = put_v ? 32'($signed(ac)) : '0;
            if (iut <= 16'd1) begin
              pending_next = 1'b1;
              iut_next     = interval;
            end else begin
              iut_next = iut - 16'd1;
            end
          end
        end
      end
      default: state_next = acpu_pkg::S_IDLE;
    endcase

    if (cfg_wen) begin
      interval_next = cfg_wdata;
      iut_next      = cfg_wdata;
    end
  end

`ifndef ASSERT_OFF
  a_mem_range: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.we |-> mem_ctl.addr < AB'(acpu_pkg::MEM_WORDS))
    else $error("memory write out of range");
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("halt state cleared");
  a_kind_kernel: assert property (@(posedge clk) disable iff (rst)
    kind != acpu_pkg::INT_NONE |-> kernel)
    else $error("interrupt active outside kernel mode");
  a_mem_err_halts: assert property (@(posedge clk) disable iff (rst)
    hs.emit && rsp.error_code == acpu_pkg::ERR_MEM |-> rsp.halted)
    else $error("memory violation without halt");
`endif

endmodule

/* sv/accumulator_cpu_with_timer_interrupt.sv */
// Top level: request buffer, response register, CPU core and main memory.
`timescale 1ns / 1ps
// Accumulator CPU with user and kernel modes and a timer interrupt. A load
// request writes one memory word and is answered; a step request runs one
// instruction as a series of memory accesses (fetch, operand, up to two data
// reads, plus two save writes when an interrupt is taken), since every
// access goes through the single-port main memory, one access per cycle.
// One request waits in the input buffer while the core works. A finished
// response waits in the output register; while it is stalled there the core
// holds its next response and takes no new load request.
module accumulator_cpu_with_timer_interrupt #(
  parameter int WORD_BITS = acpu_pkg::WORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  acpu_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output acpu_pkg::rsp_t rsp,
  input  logic           cfg_wen,
  input  logic [15:0]    cfg_wdata
);

  logic               buf_valid;
  acpu_pkg::req_t     buf_req;
  acpu_pkg::hs_t      hs;
  acpu_pkg::rsp_t     core_rsp;
  acpu_pkg::mem_ctl_t mem_ctl;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
  logic out_free;

  assign req_stall = buf_valid;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        buf_valid <= 1'b1;
      end else if (hs.take) begin
        buf_valid <= 1'b0;
      end
      if (hs.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      buf_req <= req;
    end
    if (hs.emit) begin
      rsp <= core_rsp;
    end
  end

  acpu_core #(.WORD_BITS(WORD_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .buf_valid (buf_valid),
    .buf_req   (buf_req),
    .out_free  (out_free),
    .hs        (hs),
    .rsp       (core_rsp),
    .mem_ctl   (mem_ctl),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  acpu_ram #(.WIDTH(WORD_BITS), .DEPTH(acpu_pkg::MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_ctl.we),
    .addr  (mem_ctl.addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

/* tb/accumulator_cpu_with_timer_interrupt_tb.sv */
// Testbench: self-checking random and directed test of the accumulator CPU with timer interrupt.
`timescale 1ns / 1ps
module accumulator_cpu_with_timer_interrupt_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQS = 1650;

  typedef struct {
    logic [31:0] pc, sp, ac, x, y;
    bit          kern;
    acpu_pkg::int_kind_t ik;
    bit          tpend;
    logic [15:0] cnt, ival;
    bit          stopped;
  } cpu_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  acpu_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  acpu_pkg::rsp_t rsp;
  logic           cfg_wen = 1'b0;
  logic [15:0]    cfg_wdata = '0;

  cpu_t           cpu;
  logic [31:0]    mem [acpu_pkg::MEM_WORDS];
  bit             fault, trial;
  int             undo_a[$];
  logic [31:0]    undo_v[$];
  acpu_pkg::rsp_t expected_rsp[$];
  int             errors, cycles, n_req, n_steps, n_puts, n_timer, n_sys, n_invalid, n_halts;
  int             burst_left, stall_ctr, stall_mode;
  acpu_pkg::op_t  op_list[$];

  accumulator_cpu_with_timer_interrupt dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    stall_ctr++;
    if (stall_ctr % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= $urandom_range(0, 1);
      2: rsp_stall <= (stall_ctr % 3 == 0);
      default: rsp_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    acpu_pkg::rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.port_valid !== e.port_valid) begin
          $error("port_valid exp %0d got %0d", e.port_valid, rsp.port_valid); errors++;
        end
        if (rsp.port_is_char !== e.port_is_char) begin
          $error("port_is_char exp %0d got %0d", e.port_is_char, rsp.port_is_char); errors++;
        end
        if (rsp.port_value !== e.port_value) begin
          $error("port_value exp %0d got %0d", e.port_value, rsp.port_value); errors++;
        end
        if (rsp.halted !== e.halted) begin
          $error("halted exp %0d got %0d", e.halted, rsp.halted); errors++;
        end
        if (rsp.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, rsp.error_code); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] mem_limit();
    return cpu.kern ? acpu_pkg::MEM_WORDS : acpu_pkg::USER_LIMIT;
  endfunction

  function automatic void mem_set(int a, logic [31:0] v);
    if (trial) begin
      undo_a.push_back(a);
      undo_v.push_back(mem[a]);
    end
    mem[a] = v;
  endfunction

  function automatic logic [31:0] mem_rd(logic [31:0] a);
    if (fault) return '0;
    if (a >= mem_limit()) begin
      fault = 1'b1;
      return '0;
    end
    return mem[a];
  endfunction

  function automatic void mem_wr(logic [31:0] a, logic [31:0] v);
    if (fault) return;
    if (a >= mem_limit()) begin
      fault = 1'b1;
      return;
    end
    mem_set(a, v);
  endfunction

  function automatic logic [31:0] fetch_word();
    logic [31:0] v;
    v = mem_rd(cpu.pc);
    cpu.pc++;
    return v;
  endfunction

  function automatic void load_pc(logic [31:0] v);
    if (v >= acpu_pkg::REG_LIMIT) fault = 1'b1;
    else cpu.pc = v;
  endfunction

  function automatic void load_sp(logic [31:0] v);
    if (v >= acpu_pkg::REG_LIMIT) fault = 1'b1;
    else cpu.sp = v;
  endfunction

  function automatic void push_word(logic [31:0] v);
    logic [31:0] a;
    a = cpu.sp - 1;
    mem_wr(a, v);
    if (!fault) cpu.sp = a;
  endfunction

  function automatic logic [31:0] pop_word();
    logic [31:0] v;
    v = mem_rd(cpu.sp);
    if (!fault) cpu.sp++;
    return v;
  endfunction

  function automatic void enter_handler(acpu_pkg::int_kind_t k, int vector);
    cpu.kern = 1'b1;
    cpu.ik = k;
    mem_set(acpu_pkg::SAVE_PC_ADDR, cpu.pc);
    mem_set(acpu_pkg::SAVE_SP_ADDR, cpu.sp);
    cpu.sp = acpu_pkg::SAVE_SP_ADDR;
    cpu.pc = vector;
  endfunction

  function automatic acpu_pkg::rsp_t cpu_response(acpu_pkg::req_t r);
    acpu_pkg::rsp_t o;
    logic [31:0] ir, a, s, p;
    o = '0;
    if (r.opcode == acpu_pkg::ITEM_LOAD) begin
      if (r.load_address < acpu_pkg::MEM_WORDS) mem_set(r.load_address, r.load_value);
      o.halted = cpu.stopped;
      return o;
    end
    if (cpu.stopped) begin
      o.halted = 1'b1;
      return o;
    end
    if (!trial) n_steps++;
    fault = 1'b0;
    if (cpu.tpend && cpu.ik == acpu_pkg::INT_NONE) begin
      cpu.tpend = 1'b0;
      enter_handler(acpu_pkg::INT_TIMER, acpu_pkg::TIMER_VECTOR);
      if (!trial) n_timer++;
    end
    ir = fetch_word();
    if (!fault) begin
      if (ir[31:acpu_pkg::OP_BITS] != '0) begin
        o.error_code = acpu_pkg::ERR_INVALID;
      end else begin
        case (acpu_pkg::op_t'(ir[acpu_pkg::OP_BITS-1:0]))
          acpu_pkg::OP_LOAD_VALUE: cpu.ac = fetch_word();
          acpu_pkg::OP_LOAD_ADDR: begin a = fetch_word(); cpu.ac = mem_rd(a); end
          acpu_pkg::OP_LOAD_IND: begin
            a = fetch_word(); a = mem_rd(a); cpu.ac = mem_rd(a);
          end
          acpu_pkg::OP_LOAD_IDX_X: begin a = fetch_word(); cpu.ac = mem_rd(a + cpu.x); end
          acpu_pkg::OP_LOAD_IDX_Y: begin a = fetch_word(); cpu.ac = mem_rd(a + cpu.y); end
          acpu_pkg::OP_LOAD_SP_X: cpu.ac = mem_rd(cpu.sp + cpu.x);
          acpu_pkg::OP_STORE: begin a = fetch_word(); mem_wr(a, cpu.ac); end
          acpu_pkg::OP_GET: cpu.ac = 32'(r.random_value);
          acpu_pkg::OP_PUT: begin
            p = fetch_word();
            if (!fault && (p == acpu_pkg::PUT_INT || p == acpu_pkg::PUT_CHAR)) begin
              o.port_valid = 1'b1;
              o.port_is_char = (p == acpu_pkg::PUT_CHAR);
              o.port_value = cpu.ac;
            end
          end
          acpu_pkg::OP_ADD_X: cpu.ac = cpu.ac + cpu.x;
          acpu_pkg::OP_ADD_Y: cpu.ac = cpu.ac + cpu.y;
          acpu_pkg::OP_SUB_X: cpu.ac = cpu.ac - cpu.x;
          acpu_pkg::OP_SUB_Y: cpu.ac = cpu.ac - cpu.y;
          acpu_pkg::OP_TO_X: cpu.x = cpu.ac;
          acpu_pkg::OP_FROM_X: cpu.ac = cpu.x;
          acpu_pkg::OP_TO_Y: cpu.y = cpu.ac;
          acpu_pkg::OP_FROM_Y: cpu.ac = cpu.y;
          acpu_pkg::OP_TO_SP: load_sp(cpu.ac);
          acpu_pkg::OP_FROM_SP: cpu.ac = cpu.sp;
          acpu_pkg::OP_JUMP: begin a = fetch_word(); if (!fault) load_pc(a); end
          acpu_pkg::OP_JEQ: begin
            a = fetch_word(); if (!fault && cpu.ac == 0) load_pc(a);
          end
          acpu_pkg::OP_JNE: begin
            a = fetch_word(); if (!fault && cpu.ac != 0) load_pc(a);
          end
          acpu_pkg::OP_CALL: begin
            a = fetch_word();
            push_word(cpu.pc);
            if (!fault) load_pc(a);
          end
          acpu_pkg::OP_RET: begin a = pop_word(); if (!fault) load_pc(a); end
          acpu_pkg::OP_INC_X: cpu.x = cpu.x + 1;
          acpu_pkg::OP_DEC_X: cpu.x = cpu.x - 1;
          acpu_pkg::OP_PUSH: push_word(cpu.ac);
          acpu_pkg::OP_POP: cpu.ac = pop_word();
          acpu_pkg::OP_INT: begin
            if (cpu.ik == acpu_pkg::INT_NONE) begin
              enter_handler(acpu_pkg::INT_SYSCALL, acpu_pkg::SYSCALL_VECTOR);
              if (!trial) n_sys++;
            end
          end
          acpu_pkg::OP_IRET: begin
            s = pop_word();
            p = pop_word();
            if (!fault) begin
              if (cpu.ik == acpu_pkg::INT_TIMER) cpu.tpend = 1'b0;
              cpu.ik = acpu_pkg::INT_NONE;
              cpu.kern = 1'b0;
              load_sp(s);
              load_pc(p);
            end
          end
          acpu_pkg::OP_END: begin
            cpu.stopped = 1'b1;
            o.halted = 1'b1;
            if (!trial) n_halts++;
            return o;
          end
          default: o.error_code = acpu_pkg::ERR_INVALID;
        endcase
      end
    end
    if (fault) begin
      cpu.stopped = 1'b1;
      o = '0;
      o.halted = 1'b1;
      o.error_code = acpu_pkg::ERR_MEM;
      if (!trial) n_halts++;
      return o;
    end
    if (cpu.cnt <= 1) begin
      cpu.tpend = 1'b1;
      cpu.cnt = cpu.ival;
    end else begin
      cpu.cnt--;
    end
    if (!trial && o.port_valid) n_puts++;
    if (!trial && o.error_code == acpu_pkg::ERR_INVALID) n_invalid++;
    return o;
  endfunction

  function automatic int fetch_addr();
    return (cpu.tpend && cpu.ik == acpu_pkg::INT_NONE) ? acpu_pkg::TIMER_VECTOR
                                                        : int'(cpu.pc);
  endfunction

  // Run one step on a scratch copy; report whether it keeps the CPU alive, or halts it if a halt is wanted.
  function automatic bit step_is_safe(bit do_load, int a0, logic [31:0] w0, logic [31:0] w1,
                                      bit want_halt);
    cpu_t keep;
    acpu_pkg::req_t r;
    acpu_pkg::rsp_t o;
    bit ok;
    keep = cpu;
    trial = 1'b1;
    if (do_load) begin
      mem_set(a0, w0);
      if (a0 + 1 < acpu_pkg::MEM_WORDS) mem_set(a0 + 1, w1);
    end
    r = '0;
    r.opcode = acpu_pkg::ITEM_STEP;
    o = cpu_response(r);
    ok = want_halt ? cpu.stopped : (!cpu.stopped && cpu.pc + 1 < mem_limit());
    while (undo_a.size() > 0) mem[undo_a.pop_back()] = undo_v.pop_back();
    cpu = keep;
    trial = 1'b0;
    return ok;
  endfunction

  task automatic send_req(acpu_pkg::req_t r);
    int gap;
    expected_rsp.push_back(cpu_response(r));
    n_req++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_load(int a, logic [31:0] v);
    acpu_pkg::req_t r;
    r = '0;
    r.opcode = acpu_pkg::ITEM_LOAD;
    r.load_address = a[10:0];
    r.load_value = v;
    r.random_value = 7'($urandom_range(1, 100));
    send_req(r);
  endtask

  task automatic send_step();
    acpu_pkg::req_t r;
    r = '0;
    r.opcode = acpu_pkg::ITEM_STEP;
    r.load_address = 11'($urandom);
    r.load_value = $urandom;
    r.random_value = 7'($urandom_range(1, 100));
    send_req(r);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, mem_limit() - 1);
    endcase
  endfunction

  function automatic logic [31:0] random_instr();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return $urandom | 32'h40;
    if (cpu.kern && r < 8) return 32'(acpu_pkg::OP_IRET);
    return 32'(op_list[$urandom_range(0, op_list.size() - 1)]);
  endfunction

  // Place a safe instruction at the fetch address (or, at random, reuse the safe word already there), then execute it.
  task automatic run_step(bit forced, logic [31:0] word, bit fixed, logic [31:0] opnd,
                          bit want_halt);
    int a0;
    logic [31:0] w0, w1;
    bit found;
    a0 = fetch_addr();
    found = 1'b0;
    if (!forced && !want_halt && $urandom_range(0, 1) && step_is_safe(0, a0, 0, 0, 0)) begin
      send_step();
      return;
    end
    for (int i = 0; i < 40 && !found; i++) begin
      w0 = forced ? word : random_instr();
      w1 = fixed ? opnd : random_operand();
      found = step_is_safe(1, a0, w0, w1, want_halt);
    end
    if (!found) begin
      w0 = 32'(acpu_pkg::OP_JUMP);
      w1 = (cpu.kern || a0 == acpu_pkg::TIMER_VECTOR) ? $urandom_range(1000, 1900)
                                                       : $urandom_range(0, 900);
    end
    send_load(a0, w0);
    if (a0 + 1 < acpu_pkg::MEM_WORDS) send_load(a0 + 1, w1);
    send_step();
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_interval(logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    cpu.ival = v;
    cpu.cnt = v;
  endtask

  task automatic test_fill_memory();
    send_load(0, 32'h8000_0000);
    send_load(acpu_pkg::MEM_WORDS - 1, 32'h7fff_ffff);
    send_load(2047, 32'hffff_ffff);
    send_load(acpu_pkg::MEM_WORDS, 32'h0);
    for (int a = 1; a < acpu_pkg::MEM_WORDS - 1; a++)
      send_load(a, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1999));
  endtask

  task automatic test_each_operation();
    set_interval(16'hffff);
    foreach (op_list[i]) run_step(1, 32'(op_list[i]), 0, 0, 0);
    run_step(1, 32'(acpu_pkg::OP_PUT), 1, acpu_pkg::PUT_INT, 0);
    run_step(1, 32'(acpu_pkg::OP_PUT), 1, acpu_pkg::PUT_CHAR, 0);
    run_step(1, 32'(acpu_pkg::OP_PUT), 1, 32'd7, 0);
    run_step(1, 32'd63, 0, 0, 0);
    run_step(1, 32'h8000_0009, 0, 0, 0);
    run_step(1, 32'(acpu_pkg::OP_INT), 0, 0, 0);
    run_step(1, 32'(acpu_pkg::OP_INT), 0, 0, 0);
    run_step(1, 32'(acpu_pkg::OP_IRET), 0, 0, 0);
  endtask

  task automatic test_random_programs(logic [15:0] interval, int count);
    int stop_at;
    set_interval(interval);
    stop_at = n_req + count;
    while (n_req < stop_at) begin
      case ($urandom_range(0, 19))
        0: send_load($urandom_range(acpu_pkg::MEM_WORDS, 2047), $urandom);
        1: send_load($urandom_range(0, acpu_pkg::MEM_WORDS - 3), $urandom_range(0, 1999));
        default: run_step(0, 0, 0, 0, 0);
      endcase
    end
  endtask

  task automatic test_halt();
    set_interval(16'd30);
    case ($urandom_range(0, 3))
      0: run_step(1, 32'(acpu_pkg::OP_END), 0, 0, 1);
      1: run_step(1, 32'(acpu_pkg::OP_LOAD_ADDR), 1, cpu.kern ? 32'd2000 : 32'd1000, 1);
      2: run_step(1, 32'(acpu_pkg::OP_STORE), 1, 32'hffff_fff0, 1);
      default: run_step(1, 32'(acpu_pkg::OP_JUMP), 1, 32'd3000, 1);
    endcase
    if (!cpu.stopped) run_step(1, 32'(acpu_pkg::OP_END), 0, 0, 1);
    repeat (4) send_step();
    send_load($urandom_range(0, acpu_pkg::MEM_WORDS - 1), $urandom);
    send_step();
  endtask

  initial begin
    acpu_pkg::op_t o;
    o = o.first();
    forever begin
      if (o != acpu_pkg::OP_END) op_list.push_back(o);
      if (o == o.last()) break;
      o = o.next();
    end
    cpu = '{pc: 0, sp: acpu_pkg::USER_LIMIT, ac: 0, x: 0, y: 0, kern: 0,
            ik: acpu_pkg::INT_NONE, tpend: 0, cnt: acpu_pkg::TIMER_RESET,
            ival: acpu_pkg::TIMER_RESET, stopped: 0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_interval(16'd30);
    test_fill_memory();
    test_each_operation();
    test_random_programs(16'd1, RANDOM_REQS / 5);
    test_random_programs(16'd30, RANDOM_REQS / 5);
    test_random_programs(16'($urandom_range(2, 40)), RANDOM_REQS / 5);
    test_random_programs(16'hffff, RANDOM_REQS / 5);
    test_random_programs(16'd5, RANDOM_REQS / 5);
    test_halt();
    drain();
    $display("Ran %0d requests: %0d instruction steps, %0d port writes, %0d invalid words",
             n_req, n_steps, n_puts, n_invalid);
    $display("Took %0d timer interrupts and %0d system calls; halted %0d time(s)",
             n_timer, n_sys, n_halts);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/acpu_pkg.sv
sv/acpu_ram.sv
sv/acpu_core.sv
sv/accumulator_cpu_with_timer_interrupt.sv
tb/accumulator_cpu_with_timer_interrupt_tb.sv
